### hdl/d8sdd_pkg.sv
// ----------------------------------------------------------------------------
// d8sdd_pkg
// Shared sizes, codes, the queued command type and the neighbor offset tables
// of the steepest descent direction core.
// ----------------------------------------------------------------------------
package d8sdd_pkg;

    // Heightfield store geometry
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int HEIGHT_BITS = 16;
    localparam int COL_AW      = $clog2(MAX_COLS);
    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int MEM_DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int MEM_AW      = COL_AW + ROW_AW;

    // Port field widths
    localparam int COORD_W  = 8;
    localparam int HIN_W    = 16;
    localparam int SIZE_W   = 9;
    localparam int DIR_W    = 4;
    localparam int SLOPE_W  = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    // Diagonal scale: about 65536/1.414 in Q16
    localparam int DIAG_MUL = 46349;

    // Item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd2;

    // Neighbor offset codes
    localparam logic signed [1:0] OFF_NEG  = -2'sd1;
    localparam logic signed [1:0] OFF_ZERO = 2'sd0;
    localparam logic signed [1:0] OFF_POS  = 2'sd1;

    // Command handed from the front part to the back part
    typedef struct packed {
        logic                    op;
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic [HEIGHT_BITS-1:0]  height;
    } t_cmd;

    // Column offset of neighbor k; k = 0 is the center
    function automatic logic signed [1:0] f_dx(input logic [3:0] k);
        logic signed [1:0] v;
        unique case (k)
            4'd1, 4'd7, 4'd8: v = OFF_NEG;
            4'd3, 4'd4, 4'd5: v = OFF_POS;
            default:          v = OFF_ZERO;
        endcase
        return v;
    endfunction

    // Row offset of neighbor k; k = 0 is the center
    function automatic logic signed [1:0] f_dy(input logic [3:0] k);
        logic signed [1:0] v;
        unique case (k)
            4'd1, 4'd2, 4'd3: v = OFF_NEG;
            4'd5, 4'd6, 4'd7: v = OFF_POS;
            default:          v = OFF_ZERO;
        endcase
        return v;
    endfunction

endpackage

### hdl/d8sdd_front.sv
// ----------------------------------------------------------------------------
// d8sdd_front
// Accepts items, reduces query centers by the edge mode and queues commands.
// ----------------------------------------------------------------------------
module d8sdd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_op,
    input  logic [d8sdd_pkg::COORD_W-1:0] i_col,
    input  logic [d8sdd_pkg::COORD_W-1:0] i_row,
    input  logic [d8sdd_pkg::HIN_W-1:0]   i_height,
    input  logic [d8sdd_pkg::SIZE_W-1:0]  i_cols,
    input  logic [d8sdd_pkg::SIZE_W-1:0]  i_rows,
    input  logic                          i_wrap,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output d8sdd_pkg::t_cmd               o_cmd
);
    import d8sdd_pkg::*;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [2:0]          r_cnt;
    logic [COORD_W-1:0]  r_qc, r_qr;       // dividend bits, MSB first
    logic [SIZE_W-1:0]   r_rc, r_rr;       // running remainders
    t_cmd                r_cmd;
    logic                accept;
    logic [SIZE_W-1:0]   cc_clamp, cr_clamp;
    t_cmd                in_cmd;

    // One restoring remainder step: shift in a bit, subtract if it fits
    function automatic logic [SIZE_W-1:0] f_rem_step(input logic [SIZE_W-1:0] r,
                                                     input logic b,
                                                     input logic [SIZE_W-1:0] d);
        logic [SIZE_W-1:0] t;
        t = {r[SIZE_W-2:0], b};
        if (t >= d) begin
            t = t - d;
        end
        return t;
    endfunction

    assign o_busy = (r_state != FS_IDLE) || i_q_full;
    assign accept = i_start && !o_busy;

    // Clamp the center to the size in use
    assign cc_clamp = ({1'b0, i_col} >= i_cols) ? i_cols - 1'b1 : {1'b0, i_col};
    assign cr_clamp = ({1'b0, i_row} >= i_rows) ? i_rows - 1'b1 : {1'b0, i_row};

    always_comb begin
        in_cmd.op     = i_op;
        in_cmd.col    = i_col;
        in_cmd.row    = i_row;
        in_cmd.height = i_height[HEIGHT_BITS-1:0];
        if (i_op == OP_QUERY && !i_wrap) begin
            in_cmd.col = cc_clamp[COORD_W-1:0];
            in_cmd.row = cr_clamp[COORD_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_cmd   = in_cmd;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    if (i_op == OP_QUERY && i_wrap) begin
                        n_state = FS_DIV;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
            FS_DIV: begin
                if (r_cnt == 3'd7) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                o_cmd = r_cmd;
                o_cmd.col = r_rc[COORD_W-1:0];
                o_cmd.row = r_rr[COORD_W-1:0];
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FS_DIV) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Remainder datapath: col % width and row % height, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && accept) begin
            r_cmd <= in_cmd;
            r_qc  <= i_col;
            r_qr  <= i_row;
            r_rc  <= '0;
            r_rr  <= '0;
        end else if (r_state == FS_DIV) begin
            r_rc <= f_rem_step(r_rc, r_qc[COORD_W-1], i_cols);
            r_rr <= f_rem_step(r_rr, r_qr[COORD_W-1], i_rows);
            r_qc <= {r_qc[COORD_W-2:0], 1'b0};
            r_qr <= {r_qr[COORD_W-2:0], 1'b0};
        end
    end

endmodule

### hdl/d8sdd_queue.sv
// ----------------------------------------------------------------------------
// d8sdd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module d8sdd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  d8sdd_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output d8sdd_pkg::t_cmd o_cmd
);
    import d8sdd_pkg::*;

    t_cmd       r_ent [0:1];
    logic       r_head, r_tail;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_ent[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_tail <= ~r_tail;
            end
            if (do_pop) begin
                r_head <= ~r_head;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_tail] <= i_cmd;
        end
    end

endmodule

### hdl/d8sdd_back.sv
// ----------------------------------------------------------------------------
// d8sdd_back
// Height store and query engine: writes samples, scans nine cells per query.
// ----------------------------------------------------------------------------
module d8sdd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  d8sdd_pkg::t_cmd                     i_cmd,
    input  logic [d8sdd_pkg::SIZE_W-1:0]        i_cols,
    input  logic [d8sdd_pkg::SIZE_W-1:0]        i_rows,
    input  logic                                i_wrap,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic [d8sdd_pkg::DIR_W-1:0]         o_direction,
    output logic signed [d8sdd_pkg::SLOPE_W-1:0] o_min_slope
);
    import d8sdd_pkg::*;

    logic [HEIGHT_BITS-1:0] r_mem [0:MEM_DEPTH-1];

    logic                          r_run;
    logic [3:0]                    r_step;
    logic [COORD_W-1:0]            r_cx, r_cy;
    logic [HEIGHT_BITS-1:0]        r_rdata;
    logic                          r_v1, r_v2;
    logic [3:0]                    r_k1, r_k2;
    logic [HEIGHT_BITS-1:0]        r_center;
    logic signed [SLOPE_W-1:0]     r_slope;
    logic signed [SLOPE_W-1:0]     r_best;
    logic [DIR_W-1:0]              r_dir;

    logic                          issue;
    logic [COORD_W-1:0]            nx, ny;
    logic [MEM_AW-1:0]             addr;
    logic                          mem_we;
    logic signed [HEIGHT_BITS:0]   diff;
    logic signed [HEIGHT_BITS:0]   diag_k;
    logic signed [2*HEIGHT_BITS+1:0] prod;
    logic signed [SLOPE_W-1:0]     slope;
    logic                          take;
    logic signed [SLOPE_W-1:0]     best_nx;
    logic [DIR_W-1:0]              dir_nx;

    // Neighbor coordinate with wrap or clamp at the borders
    function automatic logic [COORD_W-1:0] f_edge(input logic [COORD_W-1:0] c,
                                                  input logic signed [1:0] off,
                                                  input logic [SIZE_W-1:0] n,
                                                  input logic wrap);
        logic [SIZE_W-1:0] c9, v;
        c9 = {1'b0, c};
        v  = c9;
        if (off == OFF_NEG) begin
            if (c9 == '0) begin
                v = wrap ? n - 1'b1 : '0;
            end else begin
                v = c9 - 1'b1;
            end
        end else if (off == OFF_POS) begin
            if (c9 + 1'b1 >= n) begin
                v = wrap ? '0 : n - 1'b1;
            end else begin
                v = c9 + 1'b1;
            end
        end
        return v[COORD_W-1:0];
    endfunction

    assign o_pop  = !r_run && !i_q_empty;
    assign issue  = r_run && (r_step <= 4'd8);
    assign mem_we = o_pop && (i_cmd.op == OP_WRITE)
                    && (int'(i_cmd.col) < MAX_COLS) && (int'(i_cmd.row) < MAX_ROWS);

    assign nx = f_edge(r_cx, f_dx(r_step), i_cols, i_wrap);
    assign ny = f_edge(r_cy, f_dy(r_step), i_rows, i_wrap);

    // Single port: write address when idle, scan address when running
    assign addr = r_run ? {ny[ROW_AW-1:0], nx[COL_AW-1:0]}
                        : {i_cmd.row[ROW_AW-1:0], i_cmd.col[COL_AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= i_cmd.height;
        end
        r_rdata <= r_mem[addr];
    end

    // Stage 1: slope of the neighbor read last cycle
    assign diff   = $signed({1'b0, r_rdata}) - $signed({1'b0, r_center});
    assign diag_k = (HEIGHT_BITS+1)'(DIAG_MUL);
    assign prod   = diff * diag_k;
    assign slope  = r_k1[0] ? prod[SLOPE_W+7:8]
                            : {diff[SLOPE_W-9:0], 8'b0};

    // Stage 2: keep the first minimum
    assign take    = (r_k2 == 4'd1) || (r_slope < r_best);
    assign best_nx = take ? r_slope : r_best;
    assign dir_nx  = take ? r_k2 : r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_step  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2 && (r_k2 == 4'd8);
            r_v1    <= issue;
            r_v2    <= r_v1 && (r_k1 != 4'd0);
            if (o_pop && i_cmd.op == OP_QUERY) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (issue) begin
                r_step <= r_step + 4'd1;
            end
            if (r_v2 && r_k2 == 4'd8) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx <= i_cmd.col;
            r_cy <= i_cmd.row;
        end
        r_k1 <= r_step;
        if (r_v1) begin
            if (r_k1 == 4'd0) begin
                r_center <= r_rdata;
            end
            r_slope <= slope;
            r_k2    <= r_k1;
        end
        if (r_v2) begin
            r_best <= best_nx;
            r_dir  <= dir_nx;
            if (r_k2 == 4'd8) begin
                o_direction <= dir_nx;
                o_min_slope <= best_nx;
            end
        end
    end

endmodule

### hdl/d8_steepest_descent_direction_core.sv
// ----------------------------------------------------------------------------
// d8_steepest_descent_direction_core
// Heightfield store with a D8 steepest descent query.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   item in  | start, busy         | i_op, i_col, i_row, i_height
//   result   | o_valid (strobe)    | o_direction, o_min_slope
//   config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// A write item is accepted, then stored. In the back part a query takes a pop,
// nine reads of the single-port height memory (center, then neighbors 1..8)
// and two stages of slope and compare. In wrap mode the front part first works
// out the column and row remainders; that work overlaps the previous query in
// the back part through the queue.
// Reset clears control state only; the height memory gets no clearing pass.
// The result is a one-cycle strobe; the receiver cannot hold it off.
// ----------------------------------------------------------------------------
module d8_steepest_descent_direction_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_op,
    input  logic [d8sdd_pkg::COORD_W-1:0]         i_col,
    input  logic [d8sdd_pkg::COORD_W-1:0]         i_row,
    input  logic [d8sdd_pkg::HIN_W-1:0]           i_height,
    input  logic                                  i_cfg_we,
    input  logic [d8sdd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [d8sdd_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    output logic                                  o_valid,
    output logic [d8sdd_pkg::DIR_W-1:0]           o_direction,
    output logic signed [d8sdd_pkg::SLOPE_W-1:0]  o_min_slope
);
    import d8sdd_pkg::*;

    logic [SIZE_W-1:0] r_cols, r_rows;
    logic              r_wrap;
    logic [SIZE_W-1:0] cfg_size;

    logic q_full, q_empty, push, pop;
    t_cmd push_cmd, head_cmd;

    // Saturate a size write: zero acts as one, above the store acts as the max
    function automatic logic [SIZE_W-1:0] f_sat(input logic [SIZE_W-1:0] v,
                                                input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    assign cfg_size = i_cfg_data[SIZE_W-1:0];

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= f_sat(SIZE_W'(256), SIZE_W'(MAX_COLS));
            r_rows <= f_sat(SIZE_W'(256), SIZE_W'(MAX_ROWS));
            r_wrap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cols <= f_sat(cfg_size, SIZE_W'(MAX_COLS));
                CFG_HEIGHT: r_rows <= f_sat(cfg_size, SIZE_W'(MAX_ROWS));
                CFG_WRAP:   r_wrap <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept and classify items, reduce query centers
    d8sdd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_col    (i_col),
        .i_row    (i_row),
        .i_height (i_height),
        .i_cols   (r_cols),
        .i_rows   (r_rows),
        .i_wrap   (r_wrap),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Queue: lets the front take the next item while a query runs
    d8sdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Back: store samples, scan neighbors, emit the result strobe
    d8sdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_wrap      (r_wrap),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_direction (o_direction),
        .o_min_slope (o_min_slope)
    );

endmodule
